// ===== design/bbs_pkg.sv =====
// Shared types, constants and helpers for the binomial broadcast scheduler.
`timescale 1ns / 1ps
`default_nettype none

package bbs_pkg;

    localparam int unsigned RANK_W        = 10;  // member, root and peer ranks
    localparam int unsigned GS_W          = 11;  // group size register
    localparam int unsigned MASK_W        = 12;  // child mask, may reach 2 * 1024
    localparam int unsigned SUM_W         = 13;  // virtual rank plus twice the mask
    localparam int unsigned IDX_W         = 4;   // step position
    localparam int unsigned Q_DEPTH       = 2;   // front to back queue entries
    localparam int unsigned QP_W          = 1;   // queue pointer width
    localparam int unsigned QC_W          = 2;   // queue fill count width
    localparam int unsigned MAX_RANKS_DEF = 1024;

    typedef enum logic [1:0] {
        KIND_RECV    = 2'd0,
        KIND_SEND    = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_INVALID = 2'd3
    } t_step_kind;

    typedef enum logic [1:0] {
        JOB_INVALID = 2'd0,
        JOB_EMPTY   = 2'd1,
        JOB_TREE    = 2'd2
    } t_job_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

    // One classified request, as the back end needs it.
    typedef struct packed {
        t_job_kind           kind;
        logic                has_parent;
        logic [GS_W-1:0]     vrank;
        logic [GS_W-1:0]     parent;
        logic [MASK_W-1:0]   mask;
        logic [RANK_W-1:0]   root;
        logic [GS_W-1:0]     n;
    } t_job;

    // Map a virtual rank (below n) back to a real rank.
    function automatic logic [RANK_W-1:0] f_to_real(
        input logic [MASK_W-1:0] vpeer,
        input logic [RANK_W-1:0] root,
        input logic [GS_W-1:0]   n
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(vpeer) + SUM_W'(root);
        if (s >= SUM_W'(n)) begin
            s = s - SUM_W'(n);
        end
        return s[RANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/bbs_front.sv =====
// Front end: checks a request and works out virtual rank, parent and first mask.
`timescale 1ns / 1ps
`default_nettype none

module bbs_front
    import bbs_pkg::*;
#(
    parameter int unsigned MAX_RANKS = MAX_RANKS_DEF
) (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [RANK_W-1:0] i_member_rank,
    input  wire logic [RANK_W-1:0] i_root_rank,
    input  wire logic [GS_W-1:0]   i_group_size,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_job                   o_job
);

    logic               w_bad;
    logic [GS_W:0]      w_vsum;
    logic [GS_W-1:0]    w_vrank;
    logic [GS_W-1:0]    w_hb;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    assign w_bad = (i_group_size == '0)
                || (32'(i_group_size) > MAX_RANKS)
                || (GS_W'(i_member_rank) >= i_group_size)
                || (GS_W'(i_root_rank) >= i_group_size);

    // Subtract modulo the group size; both ranks are below n when valid.
    always_comb begin
        if (i_member_rank >= i_root_rank) begin
            w_vsum = (GS_W+1)'(i_member_rank) - (GS_W+1)'(i_root_rank);
        end else begin
            w_vsum = (GS_W+1)'(i_member_rank) + (GS_W+1)'(i_group_size)
                   - (GS_W+1)'(i_root_rank);
        end
        w_vrank = w_vsum[GS_W-1:0];
    end

    // Highest set bit of the virtual rank, one-hot.
    always_comb begin
        w_hb = '0;
        for (int i = 0; i < GS_W; i++) begin
            if (w_vrank[i]) begin
                w_hb    = '0;
                w_hb[i] = 1'b1;
            end
        end
    end

    always_comb begin
        o_job.vrank      = w_vrank;
        o_job.parent     = w_vrank ^ w_hb;
        o_job.has_parent = (w_vrank != '0);
        o_job.mask       = (w_vrank == '0) ? MASK_W'(1) : {w_hb, 1'b0};
        o_job.root       = i_root_rank;
        o_job.n          = i_group_size;
        if (w_bad) begin
            o_job.kind = JOB_INVALID;
        end else if (i_group_size == GS_W'(1)) begin
            o_job.kind = JOB_EMPTY;
        end else begin
            o_job.kind = JOB_TREE;
        end
    end

endmodule

`default_nettype wire

// ===== design/bbs_queue.sv =====
// Short queue of classified requests between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module bbs_queue
    import bbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_nonempty,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job              r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QC_W-1:0]   r_count;

    assign o_full     = (r_count == QC_W'(Q_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/bbs_back.sv =====
// Back end: walks one request's schedule, a step per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module bbs_back
    import bbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_nonempty,
    input  wire t_job               i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_step_kind,
    output logic [RANK_W-1:0]       o_peer_rank,
    output logic [IDX_W-1:0]        o_step_index,
    output logic                    o_last_step
);

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [MASK_W-1:0]  r_mask;
    logic               r_recv_pend;
    logic [IDX_W-1:0]   r_idx;

    logic               r_out_valid;
    t_step_kind         r_out_kind;
    logic [RANK_W-1:0]  r_out_peer;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic               w_emit;
    t_step_kind         w_kind;
    logic [RANK_W-1:0]  w_peer;
    logic               w_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_nonempty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (w_emit && w_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_pop  = (r_state == BK_IDLE) && i_q_nonempty;
        w_emit = (r_state == BK_RUN) && (!r_out_valid || i_ready);
    end

    // Current step.
    always_comb begin
        w_kind = KIND_INVALID;
        w_peer = '0;
        w_last = 1'b1;
        unique case (r_job.kind)
            JOB_INVALID: begin
                w_kind = KIND_INVALID;
            end
            JOB_EMPTY: begin
                w_kind = KIND_EMPTY;
            end
            JOB_TREE: begin
                if (r_recv_pend) begin
                    w_kind = KIND_RECV;
                    w_peer = f_to_real(MASK_W'(r_job.parent), r_job.root, r_job.n);
                    w_last = (SUM_W'(r_job.vrank) + SUM_W'(r_mask)) >= SUM_W'(r_job.n);
                end else begin
                    w_kind = KIND_SEND;
                    w_peer = f_to_real(MASK_W'(r_job.vrank) + r_mask, r_job.root,
                                       r_job.n);
                    w_last = (SUM_W'(r_job.vrank) + (SUM_W'(r_mask) << 1))
                             >= SUM_W'(r_job.n);
                end
            end
            default: begin
                w_kind = KIND_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_job;
            r_mask      <= i_job.mask;
            r_recv_pend <= i_job.has_parent;
            r_idx       <= '0;
        end else if (w_emit) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_recv_pend) begin
                r_recv_pend <= 1'b0;
            end else begin
                r_mask <= r_mask << 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_peer <= w_peer;
            r_out_idx  <= r_idx;
            r_out_last <= w_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_step_kind  = r_out_kind;
    assign o_peer_rank  = r_out_peer;
    assign o_step_index = r_out_idx;
    assign o_last_step  = r_out_last;

endmodule

`default_nettype wire

// ===== design/binomial_bcast_schedule.sv =====
// Top level of the binomial-tree broadcast schedule generator.
//
// Usage:
//   Write the group size on the config channel (i_cfg_valid / o_cfg_ready,
//   i_cfg_data) while the block is idle; o_cfg_ready is always high.
//   Send requests (member rank, root rank) on the input channel
//   (i_valid / o_ready). For each request the block returns its schedule as
//   a run of steps on the output channel (o_valid / i_ready): an optional
//   receive from the parent, then sends to the children, each step with its
//   index and a last flag. Bad requests give one invalid step, a group of one
//   gives one empty step.
// The first step comes out of the output register once the request has passed
//   through the queue and been loaded into the step walker. The walker emits
//   the steps one at a time, holding while the receiver stalls, and loads the
//   next request only after the last step of the one before.
// A two-entry queue parts front and back, so new requests are taken while
//   the back end still works or the receiver stalls.
// Reset clears the queue, the walker and the output register and sets the
//   group size to 1. When i_ready is low the output step holds.
`timescale 1ns / 1ps
`default_nettype none

module binomial_bcast_schedule
    import bbs_pkg::*;
#(
    parameter int unsigned MAX_RANKS = MAX_RANKS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [GS_W-1:0]   i_cfg_data,
    // request channel
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [RANK_W-1:0] i_member_rank,
    input  wire logic [RANK_W-1:0] i_root_rank,
    // step channel
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_step_kind,
    output logic [RANK_W-1:0]      o_peer_rank,
    output logic [IDX_W-1:0]       o_step_index,
    output logic                   o_last_step
);

    logic [GS_W-1:0] r_group_size;

    logic            w_q_full;
    logic            w_q_nonempty;
    logic            w_push;
    logic            w_pop;
    t_job            w_front_job;
    t_job            w_back_job;

    // The group size register takes every write; nothing else can stall it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_W'(1);
        end else if (i_cfg_valid) begin
            r_group_size <= i_cfg_data;
        end
    end

    // Front: classify the request and precompute virtual rank and masks.
    bbs_front #(
        .MAX_RANKS (MAX_RANKS)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_member_rank (i_member_rank),
        .i_root_rank   (i_root_rank),
        .i_group_size  (r_group_size),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_front_job)
    );

    // Queue: decouple request intake from step emission.
    bbs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_front_job),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .i_pop      (w_pop),
        .o_job      (w_back_job)
    );

    // Back: walk the schedule, a step per cycle while the output is not stalled.
    bbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (w_q_nonempty),
        .i_job        (w_back_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_step_kind  (o_step_kind),
        .o_peer_rank  (o_peer_rank),
        .o_step_index (o_step_index),
        .o_last_step  (o_last_step)
    );

endmodule

`default_nettype wire

// ===== bench/binomial_bcast_schedule_test.sv =====
// Self-checking testbench for the binomial-tree broadcast schedule generator.
`timescale 1ns / 1ps

module binomial_bcast_schedule_test;
    import bbs_pkg::*;

    // Generous bound: roughly 430 requests, each up to ten steps, each step
    // possibly stalled by the receiver, plus sender gaps and idle waits
    // around every group size change.
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned STEP_CAP    = 16;

    // One schedule step as it shows up on the step channel.
    typedef struct packed {
        t_step_kind          kind;
        logic [RANK_W-1:0]   peer;
        logic [IDX_W-1:0]    idx;
        logic                last;
    } t_sched_step;

    // Receiver back-pressure patterns.
    typedef enum logic [1:0] {
        RX_STEADY = 2'd0,
        RX_LIGHT  = 2'd1,
        RX_HEAVY  = 2'd2
    } t_rx_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic [GS_W-1:0]   i_cfg_data    = '0;
    logic              i_valid       = 1'b0;
    logic [RANK_W-1:0] i_member_rank = '0;
    logic [RANK_W-1:0] i_root_rank   = '0;
    logic              i_ready       = 1'b0;
    logic              o_cfg_ready;
    logic              o_ready;
    logic              o_valid;
    logic [1:0]        o_step_kind;
    logic [RANK_W-1:0] o_peer_rank;
    logic [IDX_W-1:0]  o_step_index;
    logic              o_last_step;

    // Steps predicted for accepted requests, oldest first.
    t_sched_step       expected_steps[$];
    // Our copy of the group size register.
    logic [GS_W-1:0]   cur_group_size = 11'd1;

    int unsigned       mismatches  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       burst_left  = 0;
    int unsigned       stall_left  = 0;
    bit                tx_gaps     = 1'b0;
    t_rx_mode          rx_mode     = RX_STEADY;

    binomial_bcast_schedule dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_member_rank (i_member_rank),
        .i_root_rank   (i_root_rank),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_step_kind   (o_step_kind),
        .o_peer_rank   (o_peer_rank),
        .o_step_index  (o_step_index),
        .o_last_step   (o_last_step)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binomial_bcast_schedule_test failed");
            $finish;
        end
    end

    // Receiver: stall in short bursts whose odds and length depend on the mode.
    // A free-running stall counter keeps the pattern independent of the sender.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: begin
                    i_ready <= 1'b1;
                end
                RX_LIGHT: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_left <= $urandom_range(0, 3);
                        i_ready    <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        stall_left <= $urandom_range(0, 8);
                        i_ready    <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    // Map a virtual rank back to a real one, modulo the group size.
    function automatic logic [RANK_W-1:0] to_real_rank(
        input logic [SUM_W-1:0]  vpeer,
        input logic [RANK_W-1:0] root,
        input logic [SUM_W-1:0]  n
    );
        logic [SUM_W-1:0] s;
        s = vpeer + SUM_W'(root);
        if (s >= n) begin
            s = s - n;
        end
        return s[RANK_W-1:0];
    endfunction

    // Work out the whole schedule for one request and queue its steps.
    task automatic predict_schedule(
        input logic [RANK_W-1:0] member,
        input logic [RANK_W-1:0] root
    );
        logic [SUM_W-1:0]  n;
        logic [SUM_W-1:0]  v;
        logic [SUM_W-1:0]  hb;
        logic [SUM_W-1:0]  mask;
        t_step_kind        kinds[$];
        logic [RANK_W-1:0] peers[$];
        t_sched_step       s;
        n = SUM_W'(cur_group_size);
        if (n == 0 || n > MAX_RANKS_DEF || SUM_W'(member) >= n || SUM_W'(root) >= n) begin
            // bad group size or rank outside the group: one invalid step
            kinds.push_back(KIND_INVALID);
            peers.push_back('0);
        end else if (n == 1) begin
            kinds.push_back(KIND_EMPTY);
            peers.push_back('0);
        end else begin
            if (member >= root) begin
                v = SUM_W'(member) - SUM_W'(root);
            end else begin
                v = SUM_W'(member) + n - SUM_W'(root);
            end
            if (v != 0) begin
                // parent is v with its top bit cleared; children start above it
                hb = 1;
                while ((hb << 1) <= v) begin
                    hb = hb << 1;
                end
                kinds.push_back(KIND_RECV);
                peers.push_back(to_real_rank(v - hb, root, n));
                mask = hb << 1;
            end else begin
                mask = 1;
            end
            while (v + mask < n && kinds.size() < STEP_CAP) begin
                kinds.push_back(KIND_SEND);
                peers.push_back(to_real_rank(v + mask, root, n));
                mask = mask << 1;
            end
        end
        foreach (kinds[k]) begin
            s.kind = kinds[k];
            s.peer = peers[k];
            s.idx  = IDX_W'(k);
            s.last = (k + 1 == kinds.size());
            expected_steps.push_back(s);
        end
    endtask

    // Compare every step taken from the block against the oldest prediction.
    always @(posedge i_clk) begin : check_steps
        t_sched_step want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_steps.size() == 0) begin
                report_mismatch($sformatf("unexpected step kind %0d peer %0d index %0d",
                                          o_step_kind, o_peer_rank, o_step_index));
            end else begin
                want = expected_steps.pop_front();
                if (o_step_kind != want.kind) begin
                    report_mismatch($sformatf("step kind %0d, want %0d",
                                              o_step_kind, want.kind));
                end
                if (o_peer_rank != want.peer) begin
                    report_mismatch($sformatf("peer rank %0d, want %0d",
                                              o_peer_rank, want.peer));
                end
                if (o_step_index != want.idx) begin
                    report_mismatch($sformatf("step index %0d, want %0d",
                                              o_step_index, want.idx));
                end
                if (o_last_step != want.last) begin
                    report_mismatch($sformatf("last flag %0d, want %0d",
                                              o_last_step, want.last));
                end
            end
        end
    end

    // Hold until every predicted step has come out. Call at a clock edge.
    task automatic wait_drained();
        while (expected_steps.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Offer one request, with a gap first when the current burst is used up,
    // and hold it until taken. Valid stays high so the next item can follow.
    task automatic send_request(
        input logic [RANK_W-1:0] member,
        input logic [RANK_W-1:0] root
    );
        int unsigned gap;
        gap = 0;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_member_rank <= member;
        i_root_rank   <= root;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_schedule(member, root);
    endtask

    // Change the group size only with the block idle: drop valid, let all
    // steps drain, allow for the pipeline depth, then write.
    task automatic write_group_size(input logic [GS_W-1:0] gsize);
        i_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gsize;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        cur_group_size = gsize;
        burst_left     = 0;
    endtask

    // Mostly ranks inside the group, with the group boundary and some
    // anywhere in the 10-bit range to hit the invalid path.
    function automatic logic [RANK_W-1:0] pick_rank();
        int unsigned lim;
        int unsigned r;
        lim = cur_group_size;
        if (lim == 0 || lim > MAX_RANKS_DEF) begin
            lim = MAX_RANKS_DEF;
        end
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return RANK_W'($urandom_range(0, MAX_RANKS_DEF - 1));
        end else if (r == 1) begin
            return RANK_W'(lim - 1);
        end else if (r == 2 && lim < MAX_RANKS_DEF) begin
            return RANK_W'(lim);
        end
        return RANK_W'($urandom_range(0, lim - 1));
    endfunction

    // Pick fresh idling for a phase; some phases run without any.
    task automatic shuffle_idling();
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_mode = t_rx_mode'($urandom_range(0, 2));
    endtask

    // Reset value of the group size is one: valid ranks give the empty step,
    // anything else the invalid one.
    task automatic test_default_group();
        send_request(10'd0, 10'd0);
        send_request(10'd1, 10'd0);
        send_request(10'd0, 10'd1);
        send_request(10'd1023, 10'd1023);
    endtask

    task automatic test_directed_extremes();
        // full group: root fans out ten ways, top ranks, wrap of the virtual rank
        write_group_size(11'd1024);
        send_request(10'd0, 10'd0);
        send_request(10'd1023, 10'd0);
        send_request(10'd512, 10'd0);
        send_request(10'd0, 10'd1023);
        send_request(10'd1023, 10'd1023);
        send_request(10'd341, 10'd682);
        send_request(10'd682, 10'd341);
        // smallest tree, plus a rank just past the group
        write_group_size(11'd2);
        send_request(10'd0, 10'd0);
        send_request(10'd1, 10'd0);
        send_request(10'd0, 10'd1);
        send_request(10'd2, 10'd0);
        write_group_size(11'd3);
        send_request(10'd2, 10'd1);
        send_request(10'd0, 10'd2);
        send_request(10'd1, 10'd2);
        // group sizes the block must reject
        write_group_size(11'd0);
        send_request(10'd0, 10'd0);
        write_group_size(11'd1025);
        send_request(10'd0, 10'd0);
        write_group_size(11'd2047);
        send_request(10'd5, 10'd5);
    endtask

    task automatic run_random_phase(input logic [GS_W-1:0] gsize, input int unsigned count);
        write_group_size(gsize);
        shuffle_idling();
        repeat (count) begin
            send_request(pick_rank(), pick_rank());
        end
    endtask

    task automatic test_random_schedules();
        run_random_phase(11'd1024, 60);
        run_random_phase(11'd2, 25);
        run_random_phase(11'd3, 25);
        repeat (6) begin
            run_random_phase(GS_W'($urandom_range(4, 1023)), 40);
        end
        run_random_phase(11'd1, 15);
        run_random_phase(11'd0, 10);
        run_random_phase(GS_W'($urandom_range(1025, 2047)), 10);
    endtask

    // Flood with root requests (ten steps each) under heavy stalls, pause the
    // sender until the block has emptied, then flood again.
    task automatic test_drain_pause();
        write_group_size(11'd1024);
        tx_gaps = 1'b0;
        rx_mode = RX_HEAVY;
        repeat (12) begin
            send_request(10'd77, 10'd77);
        end
        i_valid <= 1'b0;
        wait_drained();
        repeat (12) begin
            send_request(pick_rank(), pick_rank());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_group();
        test_directed_extremes();
        test_random_schedules();
        test_drain_pause();

        i_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("binomial_bcast_schedule_test passed");
        end else begin
            $display("binomial_bcast_schedule_test failed");
        end
        $finish;
    end

endmodule
